FILE: rtl/core/pscp_pkg.sv
package pscp_pkg;

	localparam int NUM_SLOTS = 4;

	localparam logic [5:0] PERIOD_PIXELS = 6'd50;
	localparam logic [5:0] FIRST_PIXEL   = 6'd1;
	localparam logic [2:0] MAX_CHANNELS  = 3'd4;
	localparam logic [1:0] PHASE_LAST    = 2'd2;
	localparam logic [1:0] PHASE_FIRST   = 2'd0;
	localparam logic [7:0] WHITE_VALUE   = 8'd0;

	localparam logic       ADDR_PER_STRING = 1'b0;

	typedef struct packed {
		logic       frame_start;
		logic [1:0] cycle_phase;
		logic       string_start;
		logic [2:0] channels_per_node;
		logic       white_last;
		logic [7:0] level_on;
		logic [7:0] level_off;
	} pscp_item_t;

	typedef struct packed {
		logic [7:0] value;
		logic       we;
		logic       last;
	} pscp_byte_t;

	typedef struct packed {
		pscp_byte_t [NUM_SLOTS-1:0] slot;
		logic [2:0]                 count;
	} pscp_pixel_t;

	typedef struct packed {
		logic [5:0] pos;
		logic [1:0] phase;
	} pscp_state_t;

	function automatic logic [1:0] phase_advance(input logic [1:0] phase);
		logic [1:0] nxt;
		unique case (phase)
			2'd0:    nxt = 2'd1;
			2'd1:    nxt = 2'd2;
			2'd2:    nxt = 2'd0;
			default: nxt = 2'd1;
		endcase
		return nxt;
	endfunction

	function automatic logic [1:0] phase_load(input logic [1:0] cycle_phase);
		return (cycle_phase > PHASE_LAST) ? PHASE_FIRST : cycle_phase;
	endfunction

	// A color channel is lit when channel index plus phase is 1 modulo 3.
	function automatic logic is_lit(input logic [1:0] chan, input logic [1:0] phase);
		logic [2:0] sum;
		sum = {1'b0, chan} + {1'b0, phase};
		return (sum == 3'd1) || (sum == 3'd4);
	endfunction

	function automatic logic is_decade(input logic [5:0] pos);
		return (pos == 6'd10) || (pos == 6'd20) || (pos == 6'd30) ||
			(pos == 6'd40) || (pos == 6'd50) || (pos == 6'd60);
	endfunction

endpackage

FILE: rtl/core/pscp_if.sv
interface pscp_in_if;
	logic       valid;
	logic       ready;
	logic       frame_start;
	logic [1:0] cycle_phase;
	logic       string_start;
	logic [2:0] channels_per_node;
	logic       white_last;
	logic [7:0] level_on;
	logic [7:0] level_off;

	modport source (
		output valid, frame_start, cycle_phase, string_start, channels_per_node,
			white_last, level_on, level_off,
		input  ready
	);
	modport sink (
		input  valid, frame_start, cycle_phase, string_start, channels_per_node,
			white_last, level_on, level_off,
		output ready
	);
endinterface

interface pscp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] channel_value;
	logic       write_enable;
	logic       last_of_pixel;

	modport source (
		output valid, channel_value, write_enable, last_of_pixel,
		input  ready
	);
	modport sink (
		input  valid, channel_value, write_enable, last_of_pixel,
		output ready
	);
endinterface

FILE: rtl/core/pscp_pixel.sv
module pscp_pixel (
	input  pscp_pkg::pscp_item_t  item,
	input  pscp_pkg::pscp_state_t cur,
	input  logic                  per_string,
	output pscp_pkg::pscp_pixel_t pix,
	output pscp_pkg::pscp_state_t nxt
);

	logic       restart;
	logic [1:0] ph0;
	logic [5:0] pos0;
	logic       full;
	logic [2:0] n;
	logic       has_white;
	logic [2:0] kk;
	logic [1:0] ci;
	logic [7:0] color;

	always_comb begin
		restart   = item.frame_start | (item.string_start & per_string);
		ph0       = restart ? pscp_pkg::phase_load(item.cycle_phase) : cur.phase;
		pos0      = restart ? pscp_pkg::FIRST_PIXEL : cur.pos;
		full      = (pos0 == pscp_pkg::PERIOD_PIXELS);
		n         = (item.channels_per_node > pscp_pkg::MAX_CHANNELS) ?
			pscp_pkg::MAX_CHANNELS : item.channels_per_node;
		has_white = (n == pscp_pkg::MAX_CHANNELS);
		kk        = 3'd0;
		ci        = 2'd0;
		color     = 8'd0;
		pix.count = n;

		for (int k = 0; k < pscp_pkg::NUM_SLOTS; k++) begin
			kk = 3'(k);
			ci = (has_white && !item.white_last) ? 2'(k - 1) : 2'(k);
			color = pscp_pkg::is_lit(ci, ph0) ? item.level_on : item.level_off;
			if (full) begin
				pix.slot[k].value = item.level_on;
				pix.slot[k].we    = 1'b1;
				pix.slot[k].last  = (kk == n - 3'd1);
			end else if (has_white && !item.white_last) begin
				pix.slot[k].value = (kk == 3'd0) ? pscp_pkg::WHITE_VALUE : color;
				pix.slot[k].we    = (kk != 3'd0);
				pix.slot[k].last  = (kk == 3'd3);
			end else if (has_white) begin
				pix.slot[k].value = (kk == 3'd3) ? pscp_pkg::WHITE_VALUE : color;
				pix.slot[k].we    = (kk != 3'd3);
				pix.slot[k].last  = (kk == 3'd3);
			end else begin
				pix.slot[k].value = color;
				pix.slot[k].we    = 1'b1;
				pix.slot[k].last  = (kk == n - 3'd1);
			end
		end

		if (full) begin
			nxt.phase = pscp_pkg::phase_advance(ph0);
			nxt.pos   = pscp_pkg::FIRST_PIXEL;
		end else begin
			nxt.phase = pscp_pkg::is_decade(pos0) ? pscp_pkg::phase_advance(ph0) : ph0;
			nxt.pos   = pos0 + 6'd1;
		end
	end

endmodule

FILE: rtl/core/pscp_serializer.sv
module pscp_serializer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  pscp_pkg::pscp_pixel_t pix,
	output logic                  free,
	pscp_out_if.source            byte_out
);

	pscp_pkg::pscp_byte_t [pscp_pkg::NUM_SLOTS-1:0] buf_q;
	logic [2:0] rem_q;
	logic       fire;

	assign fire = byte_out.valid & byte_out.ready;
	assign free = (rem_q == 3'd0) || ((rem_q == 3'd1) && fire);

	assign byte_out.valid         = (rem_q != 3'd0);
	assign byte_out.channel_value = buf_q[0].value;
	assign byte_out.write_enable  = buf_q[0].we;
	assign byte_out.last_of_pixel = buf_q[0].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (load) begin
			rem_q <= pix.count;
		end else if (fire) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= pix.slot;
		end else if (fire) begin
			for (int k = 0; k < pscp_pkg::NUM_SLOTS - 1; k++) begin
				buf_q[k] <= buf_q[k+1];
			end
		end
	end

endmodule

FILE: rtl/core/pixel_string_count_pattern_unit.sv
// Each pixel word is held in a register stage until the byte serializer can load it.
// Throughput: one byte per cycle while byte_out.ready is high; a pixel yields as many bytes
// as its channel count (clamped to four); the next pixel loads as its last byte is taken.
// Reset: arst_n clears the pixel position to 1, the color phase to 0,
// the per-string restart register to 0 and all valid flags.
module pixel_string_count_pattern_unit (
	input  logic        clk,
	input  logic        arst_n,
	pscp_in_if.sink     pixel_in,
	pscp_out_if.source  byte_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                  per_string_q;
	logic                  valid_s1;
	pscp_pkg::pscp_item_t  item_s1;
	pscp_pkg::pscp_state_t state_q;
	pscp_pkg::pscp_state_t state_nxt;
	pscp_pkg::pscp_pixel_t pix;
	logic                  ser_free;
	logic                  load;
	logic                  in_fire;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == pscp_pkg::ADDR_PER_STRING) ? {31'd0, per_string_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_string_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == pscp_pkg::ADDR_PER_STRING) begin
			per_string_q <= pwdata[0];
		end
	end

	assign load           = valid_s1 & ser_free;
	assign pixel_in.ready = !valid_s1 || ser_free;
	assign in_fire        = pixel_in.valid & pixel_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			state_q.pos   <= pscp_pkg::FIRST_PIXEL;
			state_q.phase <= pscp_pkg::PHASE_FIRST;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.frame_start       <= pixel_in.frame_start;
			item_s1.cycle_phase       <= pixel_in.cycle_phase;
			item_s1.string_start      <= pixel_in.string_start;
			item_s1.channels_per_node <= pixel_in.channels_per_node;
			item_s1.white_last        <= pixel_in.white_last;
			item_s1.level_on          <= pixel_in.level_on;
			item_s1.level_off         <= pixel_in.level_off;
		end
	end

	pscp_pixel u_pixel (
		.item       (item_s1),
		.cur        (state_q),
		.per_string (per_string_q),
		.pix        (pix),
		.nxt        (state_nxt)
	);

	pscp_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.pix      (pix),
		.free     (ser_free),
		.byte_out (byte_out)
	);

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pos != 6'd0 && state_q.pos <= pscp_pkg::PERIOD_PIXELS)
		else $error("pixel position out of range");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase != 2'd3)
		else $error("color phase out of range");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		byte_out.valid && !byte_out.write_enable |->
			byte_out.channel_value == pscp_pkg::WHITE_VALUE)
		else $error("skipped white word carries nonzero value");

	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load |=> valid_s1)
		else $error("pending pixel lost");
`endif

endmodule

FILE: bench/pixel_string_count_pattern_unit_test.sv
`timescale 1ns / 100ps

module pixel_string_count_pattern_unit_test;

	localparam int         PIXELS_PER_COLOR = 10;
	localparam int         COLOR_COUNT      = 3;
	localparam int         SETTLE_CYCLES    = 10;
	localparam logic [2:0] REG_PER_STRING   = 3'(pscp_pkg::ADDR_PER_STRING) << 2;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pscp_in_if  pixel_in ();
	pscp_out_if byte_out ();

	pixel_string_count_pattern_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel_in (pixel_in),
		.byte_out (byte_out),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	pscp_pkg::pscp_byte_t pending_bytes[$];
	logic [5:0] pos_now;
	logic [1:0] phase_now;
	logic       restart_per_string;
	bit         steady;
	int         mismatches;
	int         pixels_sent;
	int         bytes_checked;
	int         hold_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("pixel_string_count_pattern_unit: mismatch");
		$finish;
	end

	function automatic int idle_length();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic pscp_pkg::pscp_item_t make_pixel(input logic fs, input logic [1:0] cp,
			input logic ss, input logic [2:0] ch, input logic wl,
			input logic [7:0] on, input logic [7:0] off);
		pscp_pkg::pscp_item_t px;
		px.frame_start       = fs;
		px.cycle_phase       = cp;
		px.string_start      = ss;
		px.channels_per_node = ch;
		px.white_last        = wl;
		px.level_on          = on;
		px.level_off         = off;
		return px;
	endfunction

	function automatic pscp_pkg::pscp_item_t random_pixel(input int frame_pct,
			input int string_pct, input int ch_lo, input int ch_hi);
		return make_pixel($urandom_range(0, 99) < frame_pct, 2'($urandom_range(0, 3)),
			$urandom_range(0, 99) < string_pct, 3'($urandom_range(ch_lo, ch_hi)),
			1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endfunction

	function automatic void push_byte(input logic [7:0] value, input logic we,
			input logic last);
		pscp_pkg::pscp_byte_t b;
		b.value = value;
		b.we    = we;
		b.last  = last;
		pending_bytes = {pending_bytes, b};
	endfunction

	function automatic void predict_pixel(input pscp_pkg::pscp_item_t px);
		int  chans;
		int  colors;
		bit  has_white;
		bit  lit;
		chans = (px.channels_per_node > pscp_pkg::MAX_CHANNELS) ?
			int'(pscp_pkg::MAX_CHANNELS) : int'(px.channels_per_node);
		if (px.frame_start || (px.string_start && restart_per_string)) begin
			phase_now = (px.cycle_phase == 2'd3) ? 2'd0 : px.cycle_phase;
			pos_now   = pscp_pkg::FIRST_PIXEL;
		end
		if (pos_now == pscp_pkg::PERIOD_PIXELS) begin
			for (int y = 0; y < chans; y++)
				push_byte(px.level_on, 1'b1, y == chans - 1);
			phase_now = (phase_now == 2'd2) ? 2'd0 : phase_now + 2'd1;
			pos_now   = pscp_pkg::FIRST_PIXEL;
		end else begin
			colors    = (chans < COLOR_COUNT) ? chans : COLOR_COUNT;
			has_white = (chans == int'(pscp_pkg::MAX_CHANNELS));
			if (has_white && !px.white_last)
				push_byte(pscp_pkg::WHITE_VALUE, 1'b0, 1'b0);
			for (int y = 0; y < colors; y++) begin
				lit = ((y + int'(phase_now)) % COLOR_COUNT) == 1;
				push_byte(lit ? px.level_on : px.level_off, 1'b1,
					(y == colors - 1) && !(has_white && px.white_last));
			end
			if (has_white && px.white_last)
				push_byte(pscp_pkg::WHITE_VALUE, 1'b0, 1'b1);
			if ((int'(pos_now) % PIXELS_PER_COLOR) == 0)
				phase_now = (phase_now == 2'd2) ? 2'd0 : phase_now + 2'd1;
			pos_now = pos_now + 6'd1;
		end
	endfunction

	initial begin
		byte_out.ready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && byte_out.valid && byte_out.ready) begin
				if (pending_bytes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word value=%02h we=%b last=%b", $time,
						byte_out.channel_value, byte_out.write_enable,
						byte_out.last_of_pixel);
				end else begin
					pscp_pkg::pscp_byte_t exp_byte;
					exp_byte = pending_bytes.pop_front();
					bytes_checked++;
					if (byte_out.channel_value !== exp_byte.value) begin
						mismatches++;
						$display("%0t: channel_value expected %02h actual %02h", $time,
							exp_byte.value, byte_out.channel_value);
					end
					if (byte_out.write_enable !== exp_byte.we) begin
						mismatches++;
						$display("%0t: write_enable expected %b actual %b", $time,
							exp_byte.we, byte_out.write_enable);
					end
					if (byte_out.last_of_pixel !== exp_byte.last) begin
						mismatches++;
						$display("%0t: last_of_pixel expected %b actual %b", $time,
							exp_byte.last, byte_out.last_of_pixel);
					end
				end
			end
			if (steady) begin
				byte_out.ready <= 1'b1;
			end else if (hold_left > 0) begin
				byte_out.ready <= 1'b0;
				hold_left--;
			end else if ($urandom_range(0, 99) < 70) begin
				byte_out.ready <= 1'b1;
			end else begin
				byte_out.ready <= 1'b0;
				hold_left = idle_length() - 1;
			end
		end
	end

	task automatic send_pixel(input pscp_pkg::pscp_item_t px);
		int gap;
		gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_length();
		if (gap > 0) begin
			pixel_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_in.valid             <= 1'b1;
		pixel_in.frame_start       <= px.frame_start;
		pixel_in.cycle_phase       <= px.cycle_phase;
		pixel_in.string_start      <= px.string_start;
		pixel_in.channels_per_node <= px.channels_per_node;
		pixel_in.white_last        <= px.white_last;
		pixel_in.level_on          <= px.level_on;
		pixel_in.level_off         <= px.level_off;
		do @(posedge clk); while (!pixel_in.ready);
		predict_pixel(px);
		pixels_sent++;
	endtask

	task automatic wait_for_bytes();
		pixel_in.valid <= 1'b0;
		while (pending_bytes.size() > 0) @(posedge clk);
	endtask

	task automatic write_restart_mode(input logic mode);
		wait_for_bytes();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_PER_STRING;
		pwdata  <= {31'd0, mode};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		restart_per_string = mode;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'd0, mode}) begin
			mismatches++;
			$display("%0t: register read expected %08h actual %08h", $time,
				{31'd0, mode}, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_directed();
		send_pixel(make_pixel(1'b1, 2'd0, 1'b0, 3'd3, 1'b0, 8'hFF, 8'h00));
		send_pixel(make_pixel(1'b0, 2'd0, 1'b0, 3'd1, 1'b0, 8'h00, 8'hFF));
		send_pixel(make_pixel(1'b0, 2'd0, 1'b0, 3'd2, 1'b1, 8'hFF, 8'h00));
		send_pixel(make_pixel(1'b0, 2'd0, 1'b0, 3'd4, 1'b0, 8'hFF, 8'h00));
		send_pixel(make_pixel(1'b0, 2'd0, 1'b0, 3'd4, 1'b1, 8'h00, 8'hFF));
		send_pixel(make_pixel(1'b0, 2'd0, 1'b0, 3'd0, 1'b0, 8'hAA, 8'h55));
		send_pixel(make_pixel(1'b0, 2'd0, 1'b0, 3'd5, 1'b1, 8'h55, 8'hAA));
		send_pixel(make_pixel(1'b0, 2'd0, 1'b0, 3'd6, 1'b0, 8'hFF, 8'h01));
		send_pixel(make_pixel(1'b0, 2'd0, 1'b0, 3'd7, 1'b1, 8'h80, 8'h7F));
		send_pixel(make_pixel(1'b0, 2'd0, 1'b1, 3'd3, 1'b0, 8'hFF, 8'h00));
		send_pixel(make_pixel(1'b0, 2'd0, 1'b0, 3'd3, 1'b0, 8'hFE, 8'h00));
		send_pixel(make_pixel(1'b0, 2'd0, 1'b0, 3'd3, 1'b0, 8'hFF, 8'h10));
		send_pixel(make_pixel(1'b1, 2'd1, 1'b0, 3'd3, 1'b0, 8'hFF, 8'h00));
		send_pixel(make_pixel(1'b0, 2'd2, 1'b1, 3'd4, 1'b1, 8'hC3, 8'h3C));
		send_pixel(make_pixel(1'b1, 2'd2, 1'b0, 3'd4, 1'b1, 8'hFF, 8'h00));
		send_pixel(make_pixel(1'b0, 2'd0, 1'b0, 3'd3, 1'b0, 8'h0F, 8'hF0));
		send_pixel(make_pixel(1'b1, 2'd3, 1'b0, 3'd3, 1'b0, 8'hFF, 8'h00));
		send_pixel(make_pixel(1'b0, 2'd1, 1'b1, 3'd4, 1'b0, 8'hFF, 8'h00));
		for (int i = 0; i < 7; i++)
			send_pixel(make_pixel(1'b0, 2'd0, 1'b0, 3'd3, i[0], 8'hFF, 8'h00));
	endtask

	task automatic test_period_wrap();
		pscp_pkg::pscp_item_t px;
		steady = 1'b1;
		send_pixel(make_pixel(1'b1, 2'd0, 1'b0, 3'd3, 1'b0, 8'hFF, 8'h00));
		for (int i = 1; i < 105; i++) begin
			if (i == 30)
				steady = 1'b0;
			px = ($urandom_range(0, 99) < 85) ? random_pixel(0, 10, 1, 4)
				: random_pixel(0, 10, 0, 7);
			send_pixel(px);
		end
	endtask

	task automatic test_string_restart();
		pscp_pkg::pscp_item_t px;
		int         count;
		int         strings;
		int         len;
		count   = 0;
		strings = 0;
		while (count < 100) begin
			len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12)
				: $urandom_range(45, 60);
			px = random_pixel(0, 100, 1, 4);
			px.frame_start = (strings % 4) == 0;
			for (int i = 0; i < len && count < 100; i++) begin
				send_pixel(px);
				px.frame_start  = 1'b0;
				px.string_start = 1'b0;
				count++;
			end
			strings++;
			if (strings == 3)
				wait_for_bytes();
		end
	endtask

	task automatic test_random_noise(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(random_pixel(10, 25, 0, 7));
	endtask

	initial begin
		arst_n  <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		pixel_in.valid             <= 1'b0;
		pixel_in.frame_start       <= 1'b0;
		pixel_in.cycle_phase       <= '0;
		pixel_in.string_start      <= 1'b0;
		pixel_in.channels_per_node <= '0;
		pixel_in.white_last        <= 1'b0;
		pixel_in.level_on          <= '0;
		pixel_in.level_off         <= '0;
		restart_per_string = 1'b0;
		pos_now            = pscp_pkg::FIRST_PIXEL;
		phase_now          = pscp_pkg::PHASE_FIRST;
		steady             = 1'b0;
		mismatches         = 0;
		pixels_sent        = 0;
		bytes_checked      = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_period_wrap();
		write_restart_mode(1'b1);
		test_string_restart();
		test_random_noise(15);
		write_restart_mode(1'b0);
		test_random_noise(15);

		wait_for_bytes();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Drove %0d pixel words and checked %0d output words,", pixels_sent,
			bytes_checked);
		$display("with per-string restart both off and on, through full 50-pixel periods.");
		if (mismatches == 0)
			$display("pixel_string_count_pattern_unit: match");
		else
			$display("pixel_string_count_pattern_unit: mismatch");
		$finish;
	end

endmodule
